// File: hw/rtl/wnl_pkg.sv
package wnl_pkg;

  localparam int MAX_TILE_DEF    = 32;
  localparam int ENTRY_WIDTH_DEF = 16;

  localparam int CFG_W = 6;
  localparam logic [CFG_W-1:0] TILE_SIZE_RST = 6'd32;

  localparam int INDEX_W    = 15;
  localparam int VALUE_W    = 16;
  localparam int POINT_W    = 32;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 16;

  localparam int INDEX_LO = 0;
  localparam int VALUE_LO = INDEX_LO + INDEX_W;
  localparam int PX_LO    = VALUE_LO + VALUE_W;
  localparam int PY_LO    = PX_LO + POINT_W;
  localparam int PZ_LO    = PY_LO + POINT_W;

  localparam int WGT_W = 21;
  localparam logic [WGT_W-1:0] W_ONE = 21'h100000;

  localparam logic signed [OUT_DATA_W-1:0] NOISE_MAX = 16'sh7fff;
  localparam logic signed [OUT_DATA_W-1:0] NOISE_MIN = 16'sh8000;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_t;

endpackage

// File: hw/rtl/wavelet_noise_lookup_3d.sv
// Channel   Direction  Signals                        Contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser   write or evaluate request
// m_*       out        m_tvalid m_tready m_tdata m_tuser   noise result
// cfg_*     in         cfg_valid cfg_ready cfg_data       tile_size register
//
// A write request passes through S_PREP and S_WCHK from acceptance until s_tready returns.
// An evaluate request first sets up weights and wrapped indexes on one squarer and one small
// multiplier, then issues 27 taps one per cycle through the single tile memory read port,
// drains the product pipeline and loads the result into the output register.
// rst clears the control state and sets tile_size to 32; the tile contents are undefined
// until written and there is no clearing pass. A result that is not taken does not stop
// new requests; a later evaluate request waits in S_DONE until the output register is free.
module wavelet_noise_lookup_3d #(
  parameter int MAX_TILE    = wnl_pkg::MAX_TILE_DEF,
  parameter int ENTRY_WIDTH = wnl_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // entry_index, entry_value, point_x, point_y, point_z, one zero pad bit
  input  logic [wnl_pkg::IN_DATA_W-1:0]   s_tdata,
  // action
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // noise_value
  output logic [wnl_pkg::OUT_DATA_W-1:0]  m_tdata,
  // clipped
  output logic                            m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wnl_pkg::CFG_W-1:0]       cfg_data
);

  import wnl_pkg::*;

  localparam int SZW     = $clog2(MAX_TILE + 1);
  localparam int NN_W    = 2 * SZW;
  localparam int CU_W    = 3 * SZW;
  localparam int DEPTH   = MAX_TILE * MAX_TILE * MAX_TILE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CMP_W   = (CU_W > INDEX_W) ? CU_W : INDEX_W;
  localparam int MID_W   = 18;
  localparam int A_W     = 4 * ((16 + SZW + 3) / 4);
  localparam int DIG_N   = A_W / 4;
  localparam int SETUP_N = (DIG_N > 6) ? DIG_N : 6;
  localparam int CNT_W   = $clog2(SETUP_N);
  localparam int PROD_W  = WGT_W + 1 + ENTRY_WIDTH;
  localparam int ACC_W   = (ENTRY_WIDTH + 27 > 37) ? ENTRY_WIDTH + 27 : 37;
  localparam int RES_W   = ACC_W - 20;
  localparam logic [2*WGT_W-1:0] W_HALF = (2*WGT_W)'(1) << 19;
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(NOISE_MAX);
  localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(NOISE_MIN);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_WCHK  = 9'b000000100,
    S_SETUP = 9'b000001000,
    S_WRAP  = 9'b000010000,
    S_BASE  = 9'b000100000,
    S_TAP   = 9'b001000000,
    S_DRAIN = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] tile_size;
  logic [CFG_W:0]   size_even;
  logic [SZW-1:0]   n;

  logic in_fire;
  logic out_free;

  logic [POINT_W-1:0] pt   [3];
  logic [15:0]        t_in [3];
  logic [A_W-1:0]     a_in [3];

  logic               action_r;
  logic [INDEX_W-1:0] idx_r;
  logic signed [VALUE_W-1:0] val_r;

  logic [15:0]   t_ax   [3];
  logic [A_W-1:0] a_ax  [3];
  logic [SZW:0]  rem_ax [3];
  logic [SZW:0]  rem_nx [3];

  logic [WGT_W-1:0] wx [3];
  logic [WGT_W-1:0] wy [3];
  logic [WGT_W-1:0] wz [3];
  logic [SZW-1:0]   cx [3];
  logic [SZW-1:0]   cy [3];
  logic [SZW-1:0]   cz [3];
  logic [CU_W-1:0]  zb [3];
  logic [NN_W-1:0]  yb [3];
  logic [NN_W-1:0]  nn;

  logic [CNT_W-1:0] cnt;
  logic [1:0] ti;
  logic [1:0] tj;
  logic [1:0] tk;
  logic [1:0] sq_axis;
  logic [1:0] bidx;

  logic [16:0] sq_op;
  logic [33:0] sq;
  logic [WGT_W-1:0] sq_w;

  logic [SZW-1:0]  smul_a;
  logic [NN_W-1:0] smul_b;
  logic [CU_W-1:0] smul_p;

  logic [CMP_W-1:0]  idx_ext;
  logic              wr_en;
  logic [ADDR_W-1:0] raddr;
  logic [ENTRY_WIDTH-1:0] rdata;

  logic [2*WGT_W-1:0] p1;
  logic [2*WGT_W-1:0] p2;
  logic [WGT_W-1:0]   wxy_r;
  logic [WGT_W-1:0]   wz_r;
  logic [WGT_W-1:0]   wt_r;
  logic signed [ENTRY_WIDTH-1:0] e_r;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] prod_r;
  logic v1;
  logic v2;
  logic v3;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rsum;
  logic signed [RES_W-1:0] res;
  logic clip_hi;
  logic clip_lo;

  function automatic logic [SZW-1:0] wrap_inc(input logic [SZW-1:0] c,
                                               input logic [SZW-1:0] sz);
    logic [SZW-1:0] c1;
    c1 = c + SZW'(1);
    return (c1 == sz) ? '0 : c1;
  endfunction

  // Effective tile size: odd sizes round up, then clamp to the supported range.
  always_comb begin
    size_even = {1'b0, tile_size} + (CFG_W+1)'(tile_size[0]);
    if (size_even < (CFG_W+1)'(2)) begin
      n = SZW'(2);
    end else if (size_even > (CFG_W+1)'(MAX_TILE)) begin
      n = SZW'(MAX_TILE);
    end else begin
      n = SZW'(size_even);
    end
  end

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign pt[0] = s_tdata[PX_LO +: POINT_W];
  assign pt[1] = s_tdata[PY_LO +: POINT_W];
  assign pt[2] = s_tdata[PZ_LO +: POINT_W];

  // Per axis: t is the distance to the next half-integer sample, and the wrap operand is
  // mid - 1 lifted by a multiple of the tile size so that it is never negative.
  always_comb begin
    logic [15:0]      frac;
    logic [32:0]      qs;
    logic [MID_W-1:0] mid;
    for (int ax = 0; ax < 3; ax++) begin
      frac = pt[ax][15:0] ^ 16'h8000;
      qs   = {pt[ax][POINT_W-1], pt[ax]} - 33'd32768;
      mid  = {qs[32], qs[32:16]} + MID_W'(frac != 16'd0);
      t_in[ax] = 16'd0 - frac;
      a_in[ax] = A_W'($signed(mid)) - A_W'(1) + (A_W'(n) << 15);
    end
  end

  always_comb begin
    logic [SZW:0] r;
    for (int ax = 0; ax < 3; ax++) begin
      r = rem_ax[ax];
      for (int b = 3; b >= 0; b--) begin
        r = {r[SZW-1:0], a_ax[ax][A_W-4+b]};
        if (r >= {1'b0, n}) begin
          r = r - {1'b0, n};
        end
      end
      rem_nx[ax] = r;
    end
  end

  assign sq_axis = 2'(cnt >> 1);
  assign sq_op   = cnt[0] ? (17'h10000 - {1'b0, t_ax[sq_axis]}) : {1'b0, t_ax[sq_axis]};
  assign sq      = sq_op * sq_op;
  assign sq_w    = WGT_W'((sq + 34'd4096) >> 13);

  assign bidx = (cnt < CNT_W'(3)) ? 2'(cnt) : 2'(cnt - CNT_W'(3));

  always_comb begin
    smul_a = n;
    smul_b = NN_W'(n);
    case (state)
      S_WCHK: begin
        smul_b = nn;
      end
      S_BASE: begin
        if (cnt < CNT_W'(3)) begin
          smul_a = cz[bidx];
          smul_b = nn;
        end else begin
          smul_a = cy[bidx];
        end
      end
      default: begin
        smul_a = n;
      end
    endcase
  end

  assign smul_p = smul_a * smul_b;

  assign idx_ext = CMP_W'(idx_r);
  assign wr_en   = (state == S_WCHK) && (idx_ext < CMP_W'(smul_p));
  assign raddr   = ADDR_W'(zb[tk] + CU_W'(yb[tj]) + CU_W'(cx[ti]));

  wnl_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(DEPTH)
  ) u_tile (
    .clk  (clk),
    .we   (wr_en),
    .waddr(idx_ext[ADDR_W-1:0]),
    .wdata(ENTRY_WIDTH'(val_r)),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign p1     = wx[ti] * wy[tj];
  assign p2     = wxy_r * wz_r;
  assign prod_c = $signed({1'b0, wt_r}) * e_r;

  always_comb begin
    rsum    = acc + (ACC_W'(1) <<< 19);
    res     = rsum[ACC_W-1:20];
    clip_hi = res > RES_MAX;
    clip_lo = res < RES_MIN;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r <= s_tuser;
      idx_r    <= s_tdata[INDEX_LO +: INDEX_W];
      val_r    <= s_tdata[VALUE_LO +: VALUE_W];
      for (int ax = 0; ax < 3; ax++) begin
        t_ax[ax] <= t_in[ax];
        a_ax[ax] <= a_in[ax];
      end
    end
    if (state == S_PREP) begin
      nn <= NN_W'(smul_p);
    end
    if (state == S_SETUP) begin
      if (cnt < CNT_W'(DIG_N)) begin
        for (int ax = 0; ax < 3; ax++) begin
          a_ax[ax] <= a_ax[ax] << 4;
        end
      end
      if (cnt < CNT_W'(6)) begin
        unique case (sq_axis)
          2'd0:    wx[cnt[0] ? 2 : 0] <= sq_w;
          2'd1:    wy[cnt[0] ? 2 : 0] <= sq_w;
          default: wz[cnt[0] ? 2 : 0] <= sq_w;
        endcase
      end
    end
    if (state == S_WRAP) begin
      wx[1] <= W_ONE - wx[0] - wx[2];
      wy[1] <= W_ONE - wy[0] - wy[2];
      wz[1] <= W_ONE - wz[0] - wz[2];
      cx[0] <= rem_ax[0][SZW-1:0];
      cy[0] <= rem_ax[1][SZW-1:0];
      cz[0] <= rem_ax[2][SZW-1:0];
      cx[1] <= wrap_inc(rem_ax[0][SZW-1:0], n);
      cy[1] <= wrap_inc(rem_ax[1][SZW-1:0], n);
      cz[1] <= wrap_inc(rem_ax[2][SZW-1:0], n);
      cx[2] <= wrap_inc(wrap_inc(rem_ax[0][SZW-1:0], n), n);
      cy[2] <= wrap_inc(wrap_inc(rem_ax[1][SZW-1:0], n), n);
      cz[2] <= wrap_inc(wrap_inc(rem_ax[2][SZW-1:0], n), n);
    end
    if (state == S_BASE) begin
      if (cnt < CNT_W'(3)) begin
        zb[bidx] <= smul_p;
      end else begin
        yb[bidx] <= NN_W'(smul_p);
      end
    end
    wxy_r  <= WGT_W'((p1 + W_HALF) >> 20);
    wz_r   <= wz[tk];
    wt_r   <= WGT_W'((p2 + W_HALF) >> 20);
    e_r    <= rdata;
    prod_r <= prod_c;
    if (state == S_DONE && out_free) begin
      m_tuser <= clip_hi || clip_lo;
      if (clip_hi) begin
        m_tdata <= NOISE_MAX;
      end else if (clip_lo) begin
        m_tdata <= NOISE_MIN;
      end else begin
        m_tdata <= res[OUT_DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tile_size <= TILE_SIZE_RST;
      cnt       <= '0;
      ti        <= '0;
      tj        <= '0;
      tk        <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      acc       <= '0;
      m_tvalid  <= 1'b0;
      for (int ax = 0; ax < 3; ax++) begin
        rem_ax[ax] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        tile_size <= cfg_data;
      end
      v1 <= (state == S_TAP);
      v2 <= v1;
      v3 <= v2;
      if (v3) begin
        acc <= acc + ACC_W'(prod_r);
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_PREP;
            cnt   <= '0;
            acc   <= '0;
            for (int ax = 0; ax < 3; ax++) begin
              rem_ax[ax] <= '0;
            end
          end
        end
        S_PREP: begin
          state <= (action_r == ACT_WRITE) ? S_WCHK : S_SETUP;
        end
        S_WCHK: begin
          state <= S_IDLE;
        end
        S_SETUP: begin
          if (cnt < CNT_W'(DIG_N)) begin
            for (int ax = 0; ax < 3; ax++) begin
              rem_ax[ax] <= rem_nx[ax];
            end
          end
          if (cnt == CNT_W'(SETUP_N - 1)) begin
            state <= S_WRAP;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_WRAP: begin
          state <= S_BASE;
        end
        S_BASE: begin
          if (cnt == CNT_W'(5)) begin
            state <= S_TAP;
            cnt   <= '0;
            ti    <= '0;
            tj    <= '0;
            tk    <= '0;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_TAP: begin
          if (ti == 2'd2) begin
            ti <= '0;
            if (tj == 2'd2) begin
              tj <= '0;
              if (tk == 2'd2) begin
                tk    <= '0;
                state <= S_DRAIN;
              end else begin
                tk <= tk + 2'd1;
              end
            end else begin
              tj <= tj + 2'd1;
            end
          end else begin
            ti <= ti + 2'd1;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2 && !v3) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/wnl_ram.sv
module wnl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/wnl_check.sv
module wnl_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [wnl_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tuser
);

  import wnl_pkg::*;

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("s_tready high in the cycle after an accepted request");

  // A write request never produces a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == ACT_WRITE |->
      ##1 !$rose(m_tvalid) ##1 !$rose(m_tvalid) ##1 !$rose(m_tvalid))
    else $error("result produced for a write request");

  // A saturated result sits on one of the range limits.
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == NOISE_MAX || m_tdata == NOISE_MIN)
    else $error("clipped result is not at a range limit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind wavelet_noise_lookup_3d wnl_check u_wnl_check (.*);
